// File: src/letter_ngram_counter_core_defines.svh
// ----------------------------------------------------------------------------
// Letter n-gram counter: assertion macros
// Shared property forms for the port checker of the counter core.
// ----------------------------------------------------------------------------
`ifndef LETTER_NGRAM_COUNTER_CORE_DEFINES_SVH
`define LETTER_NGRAM_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LNGC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LNGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lngc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram counter package
// Sizes, codes, the command passed from front to back, and index helpers.
// ----------------------------------------------------------------------------
package lngc_pkg;

	localparam int COUNT_WIDTH  = 16;
	localparam int ALPHA        = 26;
	localparam int PAIR_CELLS   = ALPHA * ALPHA;
	localparam int TRIPLE_CELLS = ALPHA * ALPHA * ALPHA;
	localparam int PAIR_AW      = $clog2(PAIR_CELLS);
	localparam int TRIPLE_AW    = $clog2(TRIPLE_CELLS);
	localparam int LW           = 5;

	// Command queue depth, a power of two.
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	// Reads that can be in flight: queue, back stage, result register.
	localparam int READS_IN_FLIGHT = CMDQ_DEPTH + 2;

	localparam logic [7:0] CHAR_UA  = 8'h41;
	localparam logic [7:0] CHAR_UZ  = 8'h5A;
	localparam logic [7:0] CHAR_A   = 8'h61;
	localparam logic [7:0] CHAR_Z   = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam logic [LW-1:0] LAST_LETTER = LW'(ALPHA - 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef enum logic {
		FUNC_FEED = 1'b0,
		FUNC_READ = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		TBL_ANY    = 3'd0,
		TBL_START  = 3'd1,
		TBL_END    = 3'd2,
		TBL_MID    = 3'd3,
		TBL_ENDTRI = 3'd4
	} tbl_sel_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPDATE
	} bk_state_t;

	typedef struct packed {
		logic                 is_read;
		logic                 rd_zero;
		logic [2:0]           tbl;
		logic                 inc_any;
		logic                 inc_start;
		logic                 inc_end;
		logic                 inc_mid;
		logic                 inc_endtri;
		logic [PAIR_AW-1:0]   pair_addr;
		logic [TRIPLE_AW-1:0] tri_addr;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} bk_status_t;

	function automatic logic [PAIR_AW-1:0] pair_index(logic [LW-1:0] a, logic [LW-1:0] b);
		pair_index = PAIR_AW'(a) * PAIR_AW'(ALPHA) + PAIR_AW'(b);
	endfunction

	function automatic logic [TRIPLE_AW-1:0] triple_index(logic [LW-1:0] a,
		logic [LW-1:0] b, logic [LW-1:0] c);
		triple_index = TRIPLE_AW'(a) * TRIPLE_AW'(PAIR_CELLS)
			+ TRIPLE_AW'(b) * TRIPLE_AW'(ALPHA) + TRIPLE_AW'(c);
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
	endfunction

endpackage

// File: src/lngc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram counter front end
// Accepts requests, folds case, tracks the word and builds counter commands.
// ----------------------------------------------------------------------------
module lngc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic [7:0]         char_byte,
	input  logic [2:0]         table_sel,
	input  logic [4:0]         first_letter,
	input  logic [4:0]         second_letter,
	input  logic [4:0]         third_letter,
	input  lngc_pkg::bk_status_t bk_status,
	input  logic               q_full,
	output logic               q_push,
	output lngc_pkg::cmd_t     q_cmd
);
	import lngc_pkg::*;

	logic [1:0]    letters_seen_q;
	logic [LW-1:0] older_q;
	logic [LW-1:0] prior_q;
	logic [LW-1:0] last_q;

	logic          accept;
	logic [7:0]    lower;
	logic          is_letter;
	logic [LW-1:0] letter;
	logic          pair_ok;
	logic          tri_ok;
	logic          sel_ok;
	cmd_t          cmd;

	assign full   = bk_status.clearing || q_full;
	assign accept = push && !full;

	always_comb begin
		lower = char_byte;
		if (char_byte inside {[CHAR_UA:CHAR_UZ]}) begin
			lower = char_byte + CASE_GAP;
		end
		is_letter = lower inside {[CHAR_A:CHAR_Z]};
		letter    = LW'(lower - CHAR_A);
	end

	always_comb begin
		pair_ok = (first_letter <= LAST_LETTER) && (second_letter <= LAST_LETTER);
		tri_ok  = pair_ok && (third_letter <= LAST_LETTER);
		case (table_sel)
			TBL_ANY, TBL_START, TBL_END: sel_ok = pair_ok;
			TBL_MID, TBL_ENDTRI:         sel_ok = tri_ok;
			default:                     sel_ok = 1'b0;
		endcase

		cmd = '0;
		if (func == FUNC_READ) begin
			cmd.is_read = 1'b1;
			cmd.tbl     = table_sel;
			cmd.rd_zero = !sel_ok;
			// keep addresses in range; an out-of-range query reads as zero anyway
			if (pair_ok) begin
				cmd.pair_addr = pair_index(first_letter, second_letter);
			end
			if (tri_ok) begin
				cmd.tri_addr = triple_index(first_letter, second_letter, third_letter);
			end
		end else if (is_letter) begin
			cmd.inc_any   = letters_seen_q != 2'd0;
			cmd.inc_start = letters_seen_q == 2'd1;
			cmd.inc_mid   = letters_seen_q >= 2'd2;
			cmd.pair_addr = pair_index(last_q, letter);
			cmd.tri_addr  = triple_index(prior_q, last_q, letter);
		end else begin
			cmd.inc_end    = letters_seen_q >= 2'd2;
			cmd.inc_endtri = letters_seen_q == 2'd3;
			cmd.pair_addr  = pair_index(prior_q, last_q);
			cmd.tri_addr   = triple_index(older_q, prior_q, last_q);
		end
	end

	// drop feeds that touch no counter
	assign q_push = accept && (cmd.is_read || cmd.inc_any || cmd.inc_start ||
		cmd.inc_mid || cmd.inc_end || cmd.inc_endtri);
	assign q_cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letters_seen_q <= '0;
			older_q        <= '0;
			prior_q        <= '0;
			last_q         <= '0;
		end else if (accept && func == FUNC_FEED) begin
			if (is_letter) begin
				older_q <= prior_q;
				prior_q <= last_q;
				last_q  <= letter;
				if (letters_seen_q != 2'd3) begin
					letters_seen_q <= letters_seen_q + 2'd1;
				end
			end else begin
				letters_seen_q <= '0;
			end
		end
	end

endmodule

// File: src/lngc_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram counter command queue
// Short queue between front end and counter back end.
// ----------------------------------------------------------------------------
module lngc_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lngc_pkg::cmd_t cmd_in,
	output logic           full,
	input  logic           pop,
	output lngc_pkg::cmd_t cmd_out,
	output logic           empty
);
	import lngc_pkg::*;

	cmd_t               entry_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   fill_q;
	logic               do_push;
	logic               do_pop;

	assign full    = fill_q == (CMDQ_AW + 1)'(CMDQ_DEPTH);
	assign empty   = fill_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign cmd_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (CMDQ_AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (CMDQ_AW + 1)'(1);
			end
		end
	end

endmodule

// File: src/lngc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram counter back end
// Counter memories, read-modify-write, clearing pass and result register.
// ----------------------------------------------------------------------------
module lngc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  lngc_pkg::cmd_t                   q_cmd,
	output logic                             q_pop,
	output lngc_pkg::bk_status_t             bk_status,
	output logic                             empty,
	input  logic                             pop,
	output logic [lngc_pkg::COUNT_WIDTH-1:0] count
);
	import lngc_pkg::*;

	logic [COUNT_WIDTH-1:0] any_mem    [PAIR_CELLS];
	logic [COUNT_WIDTH-1:0] start_mem  [PAIR_CELLS];
	logic [COUNT_WIDTH-1:0] end_mem    [PAIR_CELLS];
	logic [COUNT_WIDTH-1:0] mid_mem    [TRIPLE_CELLS];
	logic [COUNT_WIDTH-1:0] endtri_mem [TRIPLE_CELLS];

	logic [COUNT_WIDTH-1:0] any_rd_q;
	logic [COUNT_WIDTH-1:0] start_rd_q;
	logic [COUNT_WIDTH-1:0] end_rd_q;
	logic [COUNT_WIDTH-1:0] mid_rd_q;
	logic [COUNT_WIDTH-1:0] endtri_rd_q;

	bk_state_t              state_q;
	bk_state_t              state_d;
	logic [TRIPLE_AW-1:0]   clr_addr_q;
	cmd_t                   cmd_s1;
	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   rd_en;
	logic                   out_load;
	logic [COUNT_WIDTH-1:0] rd_value;
	logic                   clr_pair;
	logic                   any_we, start_we, end_we, mid_we, endtri_we;
	logic [PAIR_AW-1:0]     pair_wa;
	logic [TRIPLE_AW-1:0]   tri_wa;
	logic [COUNT_WIDTH-1:0] any_wd, start_wd, end_wd, mid_wd, endtri_wd;

	assign bk_status.clearing = state_q == BK_CLEAR;
	assign empty = !out_valid_q;
	assign count = count_q;

	always_comb begin
		case (cmd_s1.tbl)
			TBL_ANY:    rd_value = any_rd_q;
			TBL_START:  rd_value = start_rd_q;
			TBL_END:    rd_value = end_rd_q;
			TBL_MID:    rd_value = mid_rd_q;
			TBL_ENDTRI: rd_value = endtri_rd_q;
			default:    rd_value = '0;
		endcase
		if (cmd_s1.rd_zero) begin
			rd_value = '0;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				if (clr_addr_q == TRIPLE_AW'(TRIPLE_CELLS - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					rd_en   = 1'b1;
					state_d = BK_UPDATE;
				end
			end
			BK_UPDATE: begin
				if (cmd_s1.is_read) begin
					// hold until the result register frees up
					if (!out_valid_q || pop) begin
						out_load = 1'b1;
						state_d  = BK_IDLE;
					end
				end else begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	always_comb begin
		clr_pair = clr_addr_q < TRIPLE_AW'(PAIR_CELLS);
		if (state_q == BK_CLEAR) begin
			any_we    = clr_pair;
			start_we  = clr_pair;
			end_we    = clr_pair;
			mid_we    = 1'b1;
			endtri_we = 1'b1;
			pair_wa   = clr_addr_q[PAIR_AW-1:0];
			tri_wa    = clr_addr_q;
			any_wd    = '0;
			start_wd  = '0;
			end_wd    = '0;
			mid_wd    = '0;
			endtri_wd = '0;
		end else begin
			any_we    = (state_q == BK_UPDATE) && cmd_s1.inc_any;
			start_we  = (state_q == BK_UPDATE) && cmd_s1.inc_start;
			end_we    = (state_q == BK_UPDATE) && cmd_s1.inc_end;
			mid_we    = (state_q == BK_UPDATE) && cmd_s1.inc_mid;
			endtri_we = (state_q == BK_UPDATE) && cmd_s1.inc_endtri;
			pair_wa   = cmd_s1.pair_addr;
			tri_wa    = cmd_s1.tri_addr;
			any_wd    = sat_inc(any_rd_q);
			start_wd  = sat_inc(start_rd_q);
			end_wd    = sat_inc(end_rd_q);
			mid_wd    = sat_inc(mid_rd_q);
			endtri_wd = sat_inc(endtri_rd_q);
		end
	end

	always_ff @(posedge clk) begin
		if (any_we) begin
			any_mem[pair_wa] <= any_wd;
		end
		if (start_we) begin
			start_mem[pair_wa] <= start_wd;
		end
		if (end_we) begin
			end_mem[pair_wa] <= end_wd;
		end
		if (mid_we) begin
			mid_mem[tri_wa] <= mid_wd;
		end
		if (endtri_we) begin
			endtri_mem[tri_wa] <= endtri_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			any_rd_q    <= any_mem[q_cmd.pair_addr];
			start_rd_q  <= start_mem[q_cmd.pair_addr];
			end_rd_q    <= end_mem[q_cmd.pair_addr];
			mid_rd_q    <= mid_mem[q_cmd.tri_addr];
			endtri_rd_q <= endtri_mem[q_cmd.tri_addr];
			cmd_s1      <= q_cmd;
		end
		if (out_load) begin
			count_q <= rd_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + TRIPLE_AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/letter_ngram_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram counter core
// Five saturating letter n-gram histograms over a character stream.
// ----------------------------------------------------------------------------
// Each request either feeds one text byte or reads one counter. After reset
// the core sweeps all counter memories to zero, one entry per cycle, and holds
// full high for that whole pass. A feed that touches no counter (a non-letter
// after a word shorter than two letters, or the first letter of a word)
// retires in the front end. Any other request goes to the back end: in the idle
// state it reads every counter memory at the command's addresses, then the
// update state writes the incremented counts back (or loads the result register
// for a read, waiting while an earlier result is still unpopped). The back end
// takes a new command only once it is done with the last one. A two-entry
// command queue sits between the front end and the back end, so requests keep
// flowing while a read result waits to be popped.
// ----------------------------------------------------------------------------
module letter_ngram_counter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             func,
	input  logic [7:0]                       char_byte,
	input  logic [2:0]                       table_sel,
	input  logic [4:0]                       first_letter,
	input  logic [4:0]                       second_letter,
	input  logic [4:0]                       third_letter,
	output logic                             empty,
	input  logic                             pop,
	output logic [lngc_pkg::COUNT_WIDTH-1:0] count
);
	import lngc_pkg::*;

	// front end to queue
	logic       q_push;
	cmd_t       q_cmd_in;
	logic       q_full;
	// queue to back end
	logic       q_pop;
	cmd_t       q_cmd_out;
	logic       q_empty;
	// back end status: high during the clearing pass
	bk_status_t bk_status;

	// Fold case, track the current word and turn each request into a command.
	lngc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.func          (func),
		.char_byte     (char_byte),
		.table_sel     (table_sel),
		.first_letter  (first_letter),
		.second_letter (second_letter),
		.third_letter  (third_letter),
		.bk_status     (bk_status),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd_in)
	);

	// Hold commands while the back end is busy with the previous one.
	lngc_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (q_cmd_in),
		.full    (q_full),
		.pop     (q_pop),
		.cmd_out (q_cmd_out),
		.empty   (q_empty)
	);

	// Clear the memories, then read, bump and write back counters; drive results.
	lngc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (q_cmd_out),
		.q_pop     (q_pop),
		.bk_status (bk_status),
		.empty     (empty),
		.pop       (pop),
		.count     (count)
	);

endmodule

// File: src/lngc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram counter port checker
// Watches the request and result ports of the core over time.
// ----------------------------------------------------------------------------
`include "letter_ngram_counter_core_defines.svh"

module lngc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             push,
	input logic                             full,
	input logic                             func,
	input logic                             empty,
	input logic                             pop,
	input logic [lngc_pkg::COUNT_WIDTH-1:0] count
);
	import lngc_pkg::*;

	// reads accepted but not yet popped
	logic [2:0] pending_q;
	logic       rd_in;
	logic       rd_out;

	assign rd_in  = push && !full && func == FUNC_READ;
	assign rd_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (rd_in && !rd_out) begin
			pending_q <= pending_q + 3'd1;
		end else if (rd_out && !rd_in) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	`LNGC_ASSERT_SAME(a_no_stray_result, !empty, pending_q != 3'd0, "result without a pending read")
	`LNGC_ASSERT_SAME(a_full_at_capacity, pending_q >= 3'(READS_IN_FLIGHT), full, "reads beyond capacity")
	`LNGC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(count), "waiting result changed")

endmodule

bind letter_ngram_counter_core lngc_checker u_lngc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.func   (func),
	.empty  (empty),
	.pop    (pop),
	.count  (count)
);
